### design/smacc_pkg.sv
// Shared types, codes and constants for the scatter matrix accumulator.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none
package smacc_pkg;

  // Default number of point dimensions; the block serves at most MAX_DIMS.
  localparam int DIMENSIONS_DEF = 4;
  localparam int MAX_DIMS       = 4;

  // Divider geometry: 64-bit dividend, 17-bit divisor, one bit per cycle.
  localparam int DIV_W     = 64;
  localparam int DSR_W     = 17;
  localparam int DIV_CNT_W = 7;

  // Item kinds.
  localparam logic [2:0] K_CENTER = 3'd0;
  localparam logic [2:0] K_ADD    = 3'd1;
  localparam logic [2:0] K_REMOVE = 3'd2;
  localparam logic [2:0] K_CLEAR  = 3'd3;
  localparam logic [2:0] K_READ   = 3'd4;

  // Result item codes.
  localparam logic [1:0] W_STATUS = 2'd0;
  localparam logic [1:0] W_SUM    = 2'd1;
  localparam logic [1:0] W_SCAT   = 2'd2;

  localparam logic [1:0] E_OK    = 2'd0;
  localparam logic [1:0] E_EMPTY = 2'd1;
  localparam logic [1:0] E_FULL  = 2'd2;

  // Datapath operations.
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LATCH  = 4'd1;
  localparam logic [3:0] OP_CDIFF  = 4'd2;
  localparam logic [3:0] OP_FIRST  = 4'd3;
  localparam logic [3:0] OP_CLEAR  = 4'd4;
  localparam logic [3:0] OP_PREV   = 4'd5;
  localparam logic [3:0] OP_MSTART = 4'd6;
  localparam logic [3:0] OP_MDONE  = 4'd7;
  localparam logic [3:0] OP_MUL    = 4'd8;
  localparam logic [3:0] OP_TSTART = 4'd9;
  localparam logic [3:0] OP_ACC    = 4'd10;
  localparam logic [3:0] OP_ADDSUM = 4'd11;
  localparam logic [3:0] OP_DEC    = 4'd12;
  localparam logic [3:0] OP_EMIT   = 4'd13;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] x0;
    logic signed [15:0] x1;
    logic signed [15:0] x2;
    logic signed [15:0] x3;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         which;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [47:0] value;
    logic [15:0]        count;
    logic [1:0]         error;
    logic               last;
  } out_item_t;

  // Command from controller to datapath.
  typedef struct packed {
    logic [3:0] op;
    logic [1:0] i;
    logic [1:0] j;
    logic       sub;
    logic       center;
    logic [1:0] which;
    logic [1:0] err;
    logic       last;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic cnt_full;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

### design/smacc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on smacc_pkg for its widths.
`default_nettype none
module smacc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [smacc_pkg::DIV_W-1:0]    dividend,
  input  logic [smacc_pkg::DSR_W-1:0]    divisor,
  output logic                           busy,
  output logic [smacc_pkg::DIV_W-1:0]    quo,
  output logic                           rem_nz
);
  import smacc_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [DSR_W-1:0]     rem;
  logic [DSR_W-1:0]     dsr;
  logic [DSR_W:0]       trial;
  logic [DSR_W:0]       trial_sub;
  logic                 ge;

  // One trial subtraction per cycle.
  assign trial     = {rem, quo[DIV_W-1]};
  assign ge        = trial >= {1'b0, dsr};
  assign trial_sub = trial - {1'b0, dsr};
  assign rem_nz    = |rem;

  // Control: step counter and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Payload: partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? trial_sub[DSR_W-1:0] : trial[DSR_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

### design/smacc_dp.sv
// Datapath: point register, count, sums, scatter store, multiplier and output register.
// Depends on smacc_pkg and smacc_div.
`default_nettype none
module smacc_dp #(
  parameter int DIMENSIONS = smacc_pkg::DIMENSIONS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  smacc_pkg::cmd_t          cmd,
  output smacc_pkg::stat_t         stat,
  input  smacc_pkg::in_item_t      item,
  input  logic [3:0][15:0]         center,
  output logic                     result_valid,
  input  logic                     result_stall,
  output smacc_pkg::out_item_t     result
);
  import smacc_pkg::*;

  localparam int ACT = (DIMENSIONS > MAX_DIMS) ? MAX_DIMS : ((DIMENSIONS < 1) ? 1 : DIMENSIONS);

  logic signed [15:0] xr [4];
  logic [15:0]        count;
  logic signed [31:0] sums [4];
  logic signed [47:0] scat [16];
  logic [31:0]        dmag [4];
  logic               dneg [4];
  logic [63:0]        prod;
  logic               pneg;

  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [DSR_W-1:0]   div_divisor;
  logic               div_busy;
  logic [DIV_W-1:0]   div_quo;
  logic               div_rem_nz;

  logic [15:0]        mdiv;
  logic               sneg;
  logic [31:0]        smag;
  logic signed [33:0] mean34;
  logic signed [33:0] diff34;
  logic [63:0]        mag;
  logic [63:0]        lim;
  logic [47:0]        tmag;
  logic signed [49:0] delta;
  logic signed [49:0] acc50;
  logic [3:0]         sidx;
  logic signed [47:0] emit_val;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      sat32 = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if ((v[49] != v[48]) || (v[48] != v[47])) begin
      sat48 = v[49] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end else begin
      sat48 = v[47:0];
    end
  endfunction

  // Divisor of the mean: count, or count less one when removing.
  assign mdiv = cmd.sub ? (count - 16'd1) : count;
  assign sneg = sums[cmd.i][31];
  assign smag = sneg ? (32'd0 - sums[cmd.i]) : sums[cmd.i];

  // Shared divider serves both the means and the Welford terms.
  assign div_start    = (cmd.op == OP_MSTART) || (cmd.op == OP_TSTART);
  assign div_dividend = (cmd.op == OP_MSTART) ? {32'd0, smag} : prod;
  assign div_divisor  = (cmd.op == OP_MSTART) ? {1'b0, mdiv} : ({1'b0, mdiv} + 17'd1);

  smacc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem_nz   (div_rem_nz)
  );

  // Difference from the truncated mean.
  always_comb begin
    mean34 = sneg ? -$signed({2'b00, div_quo[31:0]}) : $signed({2'b00, div_quo[31:0]});
    diff34 = $signed({{18{xr[cmd.i][15]}}, xr[cmd.i]}) - mean34;
  end

  // Scatter term: prod if centered, else prod - ceil(prod/(m+1)); clamped and signed.
  always_comb begin
    mag   = cmd.center ? prod : (prod - div_quo - {63'd0, div_rem_nz});
    lim   = pneg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
    tmag  = (mag > lim) ? lim[47:0] : mag[47:0];
    delta = (pneg ^ cmd.sub) ? -$signed({2'b00, tmag}) : $signed({2'b00, tmag});
    sidx  = {cmd.i, cmd.j};
    acc50 = $signed({{2{scat[sidx][47]}}, scat[sidx]}) + delta;
  end

  // Value of an emitted result.
  always_comb begin
    case (cmd.which)
      W_SUM:   emit_val = {{16{sums[cmd.i][31]}}, sums[cmd.i]};
      W_SCAT:  emit_val = scat[sidx];
      default: emit_val = '0;
    endcase
  end

  // Stored state: count, sums and scatter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int k = 0; k < 4; k++) begin
        sums[k] <= '0;
      end
      for (int k = 0; k < 16; k++) begin
        scat[k] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_CLEAR: begin
          count <= '0;
          for (int k = 0; k < 4; k++) begin
            sums[k] <= '0;
          end
          for (int k = 0; k < 16; k++) begin
            scat[k] <= '0;
          end
        end
        OP_FIRST: begin
          count <= 16'd1;
          for (int k = 0; k < 4; k++) begin
            sums[k] <= (k < ACT) ? {{16{xr[k][15]}}, xr[k]} : 32'sd0;
          end
          for (int k = 0; k < 16; k++) begin
            scat[k] <= '0;
          end
        end
        OP_PREV: begin
          for (int k = 0; k < ACT; k++) begin
            sums[k] <= sat32({sums[k][31], sums[k]} - {{17{xr[k][15]}}, xr[k]});
          end
        end
        OP_ADDSUM: begin
          count <= count + 16'd1;
          for (int k = 0; k < ACT; k++) begin
            sums[k] <= sat32({sums[k][31], sums[k]} + {{17{xr[k][15]}}, xr[k]});
          end
        end
        OP_DEC: begin
          count <= count - 16'd1;
        end
        OP_ACC: begin
          scat[sidx] <= sat48(acc50);
        end
        default: begin
        end
      endcase
    end
  end

  // Point register, differences and product.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        xr[0] <= item.x0;
        xr[1] <= item.x1;
        xr[2] <= item.x2;
        xr[3] <= item.x3;
      end
      OP_CDIFF: begin
        for (int k = 0; k < 4; k++) begin
          logic signed [16:0] d17;
          d17 = $signed({xr[k][15], xr[k]}) - $signed({center[k][15], center[k]});
          dneg[k] <= d17[16];
          dmag[k] <= d17[16] ? {15'd0, 17'd0 - d17} : {15'd0, d17};
        end
      end
      OP_MDONE: begin
        dneg[cmd.i] <= diff34[33];
        dmag[cmd.i] <= diff34[33] ? 32'(34'd0 - diff34) : diff34[31:0];
      end
      OP_MUL: begin
        prod <= dmag[cmd.i] * dmag[cmd.j];
        pneg <= dneg[cmd.i] ^ dneg[cmd.j];
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      result.which <= cmd.which;
      result.row   <= cmd.i;
      result.col   <= cmd.j;
      result.value <= emit_val;
      result.count <= count;
      result.error <= cmd.err;
      result.last  <= cmd.last;
    end
  end

  assign stat.cnt_zero = (count == 16'd0);
  assign stat.cnt_one  = (count == 16'd1);
  assign stat.cnt_full = (count == 16'hFFFF);
  assign stat.div_busy = div_busy;
  assign stat.out_free = !result_valid || !result_stall;

endmodule
`default_nettype wire

### design/smacc_ctrl.sv
// Controller state machine that sequences the datapath for each item kind.
// Depends on smacc_pkg for the command and status types.
`default_nettype none
module smacc_ctrl #(
  parameter int DIMENSIONS = smacc_pkg::DIMENSIONS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [2:0]        item_kind,
  input  smacc_pkg::stat_t  stat,
  output smacc_pkg::cmd_t   cmd
);
  import smacc_pkg::*;

  localparam int ACT = (DIMENSIONS > MAX_DIMS) ? MAX_DIMS : ((DIMENSIONS < 1) ? 1 : DIMENSIONS);
  localparam logic [1:0] LAST_IDX = 2'(ACT - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_MSTART = 4'd2;
  localparam logic [3:0] S_MWAIT  = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_TSTART = 4'd5;
  localparam logic [3:0] S_TWAIT  = 4'd6;
  localparam logic [3:0] S_ACC    = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;
  localparam logic [3:0] S_STATUS = 4'd9;
  localparam logic [3:0] S_RDOUT  = 4'd10;

  logic [3:0] state, state_next;
  logic [2:0] kind, kind_next;
  logic [1:0] i, i_next;
  logic [1:0] j, j_next;
  logic [1:0] err, err_next;
  logic       phase, phase_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    kind_next  = kind;
    i_next     = i;
    j_next     = j;
    err_next   = err;
    phase_next = phase;
    cmd        = '0;
    cmd.i      = i;
    cmd.j      = j;
    cmd.sub    = (kind == K_REMOVE);
    cmd.center = (kind == K_CENTER);
    cmd.err    = err;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.op     = OP_LATCH;
          kind_next  = item_kind;
          err_next   = E_OK;
          i_next     = '0;
          j_next     = '0;
          phase_next = 1'b0;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (kind)
          K_CENTER: begin
            if (stat.cnt_full) begin
              err_next   = E_FULL;
              state_next = S_STATUS;
            end else begin
              cmd.op     = OP_CDIFF;
              state_next = S_MUL;
            end
          end
          K_ADD: begin
            if (stat.cnt_full) begin
              err_next   = E_FULL;
              state_next = S_STATUS;
            end else if (stat.cnt_zero) begin
              cmd.op     = OP_FIRST;
              state_next = S_STATUS;
            end else begin
              state_next = S_MSTART;
            end
          end
          K_REMOVE: begin
            if (stat.cnt_zero) begin
              err_next   = E_EMPTY;
              state_next = S_STATUS;
            end else if (stat.cnt_one) begin
              cmd.op     = OP_CLEAR;
              state_next = S_STATUS;
            end else begin
              cmd.op     = OP_PREV;
              state_next = S_MSTART;
            end
          end
          K_CLEAR: begin
            cmd.op     = OP_CLEAR;
            state_next = S_STATUS;
          end
          K_READ: begin
            state_next = S_RDOUT;
          end
          default: begin
            state_next = S_STATUS;
          end
        endcase
      end
      S_MSTART: begin
        cmd.op     = OP_MSTART;
        state_next = S_MWAIT;
      end
      S_MWAIT: begin
        if (!stat.div_busy) begin
          cmd.op = OP_MDONE;
          if (i == LAST_IDX) begin
            i_next     = '0;
            j_next     = '0;
            state_next = S_MUL;
          end else begin
            i_next     = i + 2'd1;
            state_next = S_MSTART;
          end
        end
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = (kind == K_CENTER) ? S_ACC : S_TSTART;
      end
      S_TSTART: begin
        cmd.op     = OP_TSTART;
        state_next = S_TWAIT;
      end
      S_TWAIT: begin
        if (!stat.div_busy) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (j == LAST_IDX) begin
          j_next = '0;
          if (i == LAST_IDX) begin
            i_next     = '0;
            state_next = S_FIN;
          end else begin
            i_next     = i + 2'd1;
            state_next = S_MUL;
          end
        end else begin
          j_next     = j + 2'd1;
          state_next = S_MUL;
        end
      end
      S_FIN: begin
        cmd.op     = (kind == K_REMOVE) ? OP_DEC : OP_ADDSUM;
        state_next = S_STATUS;
      end
      S_STATUS: begin
        cmd.i     = '0;
        cmd.j     = '0;
        cmd.which = W_STATUS;
        cmd.last  = 1'b1;
        if (stat.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      S_RDOUT: begin
        // Sums first, then the scatter matrix row by row.
        if (!phase) begin
          cmd.which = W_SUM;
          cmd.j     = '0;
        end else begin
          cmd.which = W_SCAT;
          cmd.last  = (i == LAST_IDX) && (j == LAST_IDX);
        end
        if (stat.out_free) begin
          cmd.op = OP_EMIT;
          if (!phase) begin
            if (i == LAST_IDX) begin
              i_next     = '0;
              phase_next = 1'b1;
            end else begin
              i_next = i + 2'd1;
            end
          end else if (j == LAST_IDX) begin
            j_next = '0;
            if (i == LAST_IDX) begin
              i_next     = '0;
              phase_next = 1'b0;
              state_next = S_IDLE;
            end else begin
              i_next = i + 2'd1;
            end
          end else begin
            j_next = j + 2'd1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= K_CENTER;
      i     <= '0;
      j     <= '0;
      err   <= E_OK;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      i     <= i_next;
      j     <= j_next;
      err   <= err_next;
      phase <= phase_next;
    end
  end

endmodule
`default_nettype wire

### design/scatter_matrix_accumulator.sv
// Clear, unused kinds and status-only items go straight to the status result; a center add
// multiplies and accumulates the D*D terms; a running add or remove forms each mean, then each
// Welford term, on the shared one-bit-per-cycle divider (64 steps per mean and per Welford term).
// Read out gives one item per cycle unless stalled, D + D*D items. One item is worked at a time.
// Reset (synchronous) clears count, sums, scatter and centers at once; no clearing pass.
// Depends on smacc_pkg, smacc_ctrl, smacc_dp and smacc_div.
`default_nettype none
module scatter_matrix_accumulator #(
  parameter int DIMENSIONS = smacc_pkg::DIMENSIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  smacc_pkg::in_item_t   item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output smacc_pkg::out_item_t  result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import smacc_pkg::*;

  logic [3:0][15:0] center;
  cmd_t             cmd;
  stat_t            stat;

  // Center registers on the configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= '0;
    end else if (psel && penable && pwrite) begin
      center[paddr[3:2]] <= pwdata[15:0];
    end
  end

  assign prdata = {{16{center[paddr[3:2]][15]}}, center[paddr[3:2]]};

  smacc_ctrl #(
    .DIMENSIONS (DIMENSIONS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_kind  (item.kind),
    .stat       (stat),
    .cmd        (cmd)
  );

  smacc_dp #(
    .DIMENSIONS (DIMENSIONS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .item         (item),
    .center       (center),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire
